// ===== rtl/bee_pkg.sv =====
package bee_pkg;

    localparam int unsigned RUN_MAX   = 6;
    localparam int unsigned RUN_CNT_W = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 64;
    localparam int unsigned SET_W     = 256;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_LOW    = 3'd0,
        REG_SET_SECOND = 3'd1,
        REG_SET_THIRD  = 3'd2,
        REG_SET_HIGH   = 3'd3,
        REG_NP_ONLY    = 3'd4,
        REG_C_STYLE    = 3'd5,
        REG_UNICODE    = 3'd6
    } cfg_idx_t;

    // ascii codes used by the escapes
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7e;

    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0a;
    localparam logic [7:0] CTL_FF  = 8'h0c;
    localparam logic [7:0] CTL_CR  = 8'h0d;

    typedef struct packed {
        logic [SET_W-1:0] esc_set;
        logic             np_only;
        logic             c_style;
        logic             unicode;
    } esc_cfg_t;

    // byte 0 goes out first
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    len;
    } run_t;

endpackage

// ===== rtl/bee_ifs.sv =====
interface bee_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface bee_esc_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;

    modport source (output valid, output out_byte, output run_last, output text_last,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input text_last,
                  output ready);
endinterface

interface bee_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bee_run_build.sv =====
module bee_run_build
    import bee_pkg::*;
(
    input  logic [7:0] in_byte,
    input  esc_cfg_t   cfg,
    output run_t       run
);

    logic       printable;
    logic       member;
    logic       escape;
    logic [7:0] ctl_letter;
    logic       has_ctl;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10)
            return CH_ZERO + {4'd0, v};
        else
            return CH_LOWER_A + {4'd0, v} - 8'd10;
    endfunction

    always_comb
    begin
        printable = (in_byte >= CH_SPACE) && (in_byte <= CH_TILDE);
        member    = cfg.esc_set[in_byte];
        escape    = member && !(cfg.np_only && printable);

        has_ctl    = 1'b1;
        ctl_letter = 8'h00;
        unique case (in_byte)
            CTL_LF:  ctl_letter = CH_N;
            CTL_CR:  ctl_letter = CH_R;
            CTL_BS:  ctl_letter = CH_B;
            CTL_FF:  ctl_letter = CH_F;
            CTL_TAB: ctl_letter = CH_T;
            CTL_BEL: ctl_letter = CH_LOWER_A;
            default: has_ctl = 1'b0;
        endcase

        run.bytes = '0;
        if (escape && cfg.c_style && printable)
        begin
            run.bytes[0] = CH_BACKSLASH;
            run.bytes[1] = in_byte;
            run.len      = RUN_CNT_W'(2);
        end
        else if (escape && cfg.c_style && has_ctl)
        begin
            run.bytes[0] = CH_BACKSLASH;
            run.bytes[1] = ctl_letter;
            run.len      = RUN_CNT_W'(2);
        end
        else if (escape && cfg.unicode && !printable)
        begin
            run.bytes[0] = CH_BACKSLASH;
            run.bytes[1] = CH_U;
            run.bytes[2] = CH_ZERO;
            run.bytes[3] = CH_ZERO;
            run.bytes[4] = hex_digit(in_byte[7:4]);
            run.bytes[5] = hex_digit(in_byte[3:0]);
            run.len      = RUN_CNT_W'(6);
        end
        else
        begin
            run.bytes[0] = in_byte;
            run.len      = RUN_CNT_W'(1);
        end
    end

endmodule

// ===== rtl/byte_escape_encoder.sv =====
// byte escape encoder: each text byte becomes a run of one, two or six output
// bytes (pass-through, backslash form, or \u00xx with lowercase hex). the run
// is built in the cycle the byte is taken and loaded into a six-byte output
// register that drains one byte per transaction on the escaped channel, so an
// unescaped stream flows at one byte per cycle while the escaped side is ready,
// and an escape holds the input until its run has drained. the next text byte is
// taken in the same cycle the last byte of the current run is handed off.
// configuration writes are always taken (cfg.ready is high) and should only
// be issued while the block is idle.
module byte_escape_encoder
    import bee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bee_cfg_if.sink     cfg,
    bee_text_if.sink    text,
    bee_esc_if.source   escaped
);

    // configuration registers
    logic [CFG_DAT_W-1:0] set_low_reg;
    logic [CFG_DAT_W-1:0] set_second_reg;
    logic [CFG_DAT_W-1:0] set_third_reg;
    logic [CFG_DAT_W-1:0] set_high_reg;
    logic                 np_only_reg;
    logic                 c_style_reg;
    logic                 unicode_reg;

    esc_cfg_t esc_cfg;
    run_t     new_run;

    // output run register: bytes shift down as they leave
    logic [RUN_MAX-1:0][7:0] run_reg;
    logic [RUN_MAX-1:0][7:0] run_next;
    logic [RUN_CNT_W-1:0]    count_reg;
    logic [RUN_CNT_W-1:0]    count_next;
    logic                    end_reg;
    logic                    end_next;

    logic out_take;
    logic in_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_low_reg    <= '1;
            set_second_reg <= '1;
            set_third_reg  <= '1;
            set_high_reg   <= '1;
            np_only_reg    <= 1'b0;
            c_style_reg    <= 1'b1;
            unicode_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            // indexes past the list are dropped
            unique case (cfg.index)
                REG_SET_LOW:    set_low_reg    <= cfg.data;
                REG_SET_SECOND: set_second_reg <= cfg.data;
                REG_SET_THIRD:  set_third_reg  <= cfg.data;
                REG_SET_HIGH:   set_high_reg   <= cfg.data;
                REG_NP_ONLY:    np_only_reg    <= cfg.data[0];
                REG_C_STYLE:    c_style_reg    <= cfg.data[0];
                REG_UNICODE:    unicode_reg    <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // bit n of the set is byte value n
    assign esc_cfg.esc_set = {set_high_reg, set_third_reg, set_second_reg, set_low_reg};
    assign esc_cfg.np_only = np_only_reg;
    assign esc_cfg.c_style = c_style_reg;
    assign esc_cfg.unicode = unicode_reg;

    bee_run_build u_build (
        .in_byte (text.in_byte),
        .cfg     (esc_cfg),
        .run     (new_run)
    );

    // handshake: take a new byte when the run register is empty or its
    // last byte leaves in this cycle
    assign out_take   = escaped.valid && escaped.ready;
    assign text.ready = (count_reg == '0) || ((count_reg == RUN_CNT_W'(1)) && escaped.ready);
    assign in_take    = text.valid && text.ready;

    always_comb
    begin
        run_next   = run_reg;
        count_next = count_reg;
        end_next   = end_reg;
        if (in_take)
        begin
            run_next   = new_run.bytes;
            count_next = new_run.len;
            end_next   = text.string_end;
        end
        else if (out_take)
        begin
            run_next   = run_reg >> 8;
            count_next = count_reg - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        end_reg <= end_next;
    end

    assign escaped.valid     = (count_reg != '0);
    assign escaped.out_byte  = run_reg[0];
    assign escaped.run_last  = (count_reg == RUN_CNT_W'(1));
    assign escaped.text_last = (count_reg == RUN_CNT_W'(1)) && end_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a new byte never overwrites a run that still has bytes left to send
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (count_reg == '0) || ((count_reg == RUN_CNT_W'(1)) && out_take))
        else $error("text byte taken over an unfinished run");

    // every taken byte produces output in the following cycle
    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> escaped.valid)
        else $error("no output after a text byte was taken");

    // run length never exceeds the longest escape
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RUN_CNT_W'(RUN_MAX))
        else $error("run count out of range");

    // a stalled run keeps its remaining length
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (escaped.valid && !escaped.ready) |=> (count_reg == $past(count_reg)))
        else $error("run length changed while output stalled");

endmodule

// ===== bench/escape_checker.sv =====
`timescale 1ns / 1ps

module escape_checker
    import bee_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bee_cfg_if    cfg,
    bee_text_if   text,
    bee_esc_if    escaped,
    output int    fail_count,
    output int    pending
);

    localparam logic [7:0] NO_LETTER = 8'h00;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_last;
    } escaped_byte_t;

    // expected output bytes, oldest first
    escaped_byte_t run_bytes_q[$];

    // local copy of the configuration
    logic [SET_W-1:0] esc_set = '1;
    logic             np_only = 1'b0;
    logic             c_style = 1'b1;
    logic             unicode = 1'b0;

    int fails = 0;

    function automatic logic [7:0] control_letter(input logic [7:0] b);
        case (b)
            CTL_LF:  return CH_N;
            CTL_CR:  return CH_R;
            CTL_BS:  return CH_B;
            CTL_FF:  return CH_F;
            CTL_TAB: return CH_T;
            CTL_BEL: return CH_LOWER_A;
            default: return NO_LETTER;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_LOWER_A + 8'(v) - 8'd10;
    endfunction

    // works out the run of bytes one text byte turns into and queues it
    function automatic void predict_escape_run(input logic [7:0] b, input logic last);
        logic [7:0]    seq [RUN_MAX];
        int            n;
        logic          printable;
        logic          escape;
        logic [7:0]    letter;
        escaped_byte_t item;
        printable = (b >= CH_SPACE) && (b <= CH_TILDE);
        escape    = esc_set[b] && !(np_only && printable);
        letter    = control_letter(b);
        if (escape && c_style && printable) begin
            seq[0] = CH_BACKSLASH;
            seq[1] = b;
            n = 2;
        end else if (escape && c_style && letter != NO_LETTER) begin
            seq[0] = CH_BACKSLASH;
            seq[1] = letter;
            n = 2;
        end else if (escape && unicode && !printable) begin
            seq[0] = CH_BACKSLASH;
            seq[1] = CH_U;
            seq[2] = CH_ZERO;
            seq[3] = CH_ZERO;
            seq[4] = hex_char(b[7:4]);
            seq[5] = hex_char(b[3:0]);
            n = 6;
        end else begin
            seq[0] = b;
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            item.out_byte  = seq[k];
            item.run_last  = (k == n - 1);
            item.text_last = (k == n - 1) && last;
            run_bytes_q.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        escaped_byte_t want;
        if (!rst_n) begin
            esc_set = '1;
            np_only = 1'b0;
            c_style = 1'b1;
            unicode = 1'b0;
            run_bytes_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_SET_LOW:    esc_set[63:0]    = cfg.data;
                    REG_SET_SECOND: esc_set[127:64]  = cfg.data;
                    REG_SET_THIRD:  esc_set[191:128] = cfg.data;
                    REG_SET_HIGH:   esc_set[255:192] = cfg.data;
                    REG_NP_ONLY:    np_only = cfg.data[0];
                    REG_C_STYLE:    c_style = cfg.data[0];
                    REG_UNICODE:    unicode = cfg.data[0];
                    default:        ;
                endcase
            end
            if (text.valid && text.ready)
                predict_escape_run(text.in_byte, text.string_end);
            if (escaped.valid && escaped.ready) begin
                if (run_bytes_q.size() == 0) begin
                    $display("%0t: unexpected output byte %h (run_last %b text_last %b)",
                             $time, escaped.out_byte, escaped.run_last, escaped.text_last);
                    fails++;
                end else begin
                    want = run_bytes_q.pop_front();
                    if (escaped.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.out_byte, escaped.out_byte);
                        fails++;
                    end
                    if (escaped.run_last !== want.run_last) begin
                        $display("%0t: run_last expected %b actual %b (byte %h)",
                                 $time, want.run_last, escaped.run_last, want.out_byte);
                        fails++;
                    end
                    if (escaped.text_last !== want.text_last) begin
                        $display("%0t: text_last expected %b actual %b (byte %h)",
                                 $time, want.text_last, escaped.text_last, want.out_byte);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= run_bytes_q.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bee_pkg::*;

    // index past the end of the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int BYTES_PER_PHASE = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   no_idle = 1'b0;
    int   cycles = 0;
    int   fail_count;
    int   pending;
    int   stall_left = 0;

    bee_cfg_if  cfg_ch ();
    bee_text_if text_ch ();
    bee_esc_if  esc_ch ();

    byte_escape_encoder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .text    (text_ch),
        .escaped (esc_ch)
    );

    escape_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .text       (text_ch),
        .escaped    (esc_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // every input known from time zero
    initial begin
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        text_ch.valid      = 1'b0;
        text_ch.in_byte    = '0;
        text_ch.string_end = 1'b0;
        esc_ch.ready       = 1'b0;
    end

    // run guard: a hang anywhere ends up here
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** byte_escape_encoder: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure: random stalls, none in the quiet tail
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            esc_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            esc_ch.ready <= 1'b0;
        end else begin
            esc_ch.ready <= 1'b1;
        end
    end

    // one text transaction, sometimes preceded by an idle burst;
    // valid stays high between back-to-back bytes
    task automatic send_text(input logic [7:0] b, input logic last);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        text_ch.valid      <= 1'b1;
        text_ch.in_byte    <= b;
        text_ch.string_end <= last;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
    endtask

    // stop sending and hold off until every expected byte has come out
    task automatic settle();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write transaction, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // random set word, with all-ones and all-zeros showing up often
    function automatic logic [63:0] set_word();
        case ($urandom_range(0, 3))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mode word: only bit 0 counts, the upper bits are junk
    function automatic logic [63:0] mode_word(input logic bit0);
        logic [31:0] junk;
        junk = $urandom;
        return {$urandom, junk[31:1], bit0};
    endfunction

    initial begin
        logic [63:0] sets [4];
        logic        np_val;
        logic        c_val;
        logic        u_val;
        int          sent;
        int          len;
        logic [7:0]  b;
        logic        last;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: full set, c-style on, unicode off
        send_text(8'h00, 1'b0);   // nonprintable, no c letter, passes through
        send_text(CTL_BEL, 1'b0);
        send_text(CTL_BS, 1'b0);
        send_text(CTL_TAB, 1'b0);
        send_text(CTL_LF, 1'b0);
        send_text(CTL_FF, 1'b0);
        send_text(CTL_CR, 1'b0);
        send_text(CH_SPACE, 1'b0);      // printable extremes get a backslash
        send_text(CH_TILDE, 1'b0);
        send_text(CH_BACKSLASH, 1'b0);
        send_text(8'h7f, 1'b0);
        send_text(8'hff, 1'b1);
        settle();

        // unicode on: high bytes give unsigned hex, c escapes still win
        write_reg(REG_UNICODE, mode_word(1'b1));
        send_text(8'h00, 1'b0);
        send_text(8'h80, 1'b0);
        send_text(8'h9a, 1'b0);
        send_text(8'hff, 1'b0);
        send_text(CTL_LF, 1'b0);
        send_text(8'h1f, 1'b1);
        settle();

        // c-style off: printable passes even with unicode on
        write_reg(REG_C_STYLE, mode_word(1'b0));
        send_text(8'h41, 1'b0);
        send_text(CTL_TAB, 1'b1);
        settle();

        // nonprintable-only: printable bytes never escaped
        write_reg(REG_NP_ONLY, mode_word(1'b1));
        write_reg(REG_C_STYLE, mode_word(1'b1));
        send_text(8'h41, 1'b0);
        send_text(CTL_CR, 1'b1);
        settle();

        // empty set: everything passes through
        write_reg(REG_SET_LOW, '0);
        write_reg(REG_SET_SECOND, '0);
        write_reg(REG_SET_THIRD, '0);
        write_reg(REG_SET_HIGH, '0);
        write_reg(REG_NP_ONLY, mode_word(1'b0));
        send_text(CH_BACKSLASH, 1'b0);
        send_text(CTL_LF, 1'b0);
        send_text(8'hc3, 1'b1);

        // random phases, each with a fresh configuration; first two are the extremes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            for (int i = 0; i < 4; i++)
                sets[i] = (phase == 0) ? '1 : (phase == 1) ? '0 : set_word();
            np_val = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom);
            c_val  = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom);
            u_val  = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom);
            write_reg(REG_SET_LOW, sets[0]);
            write_reg(REG_SET_SECOND, sets[1]);
            write_reg(REG_SET_THIRD, sets[2]);
            write_reg(REG_SET_HIGH, sets[3]);
            write_reg(REG_NP_ONLY, mode_word(np_val));
            write_reg(REG_C_STYLE, mode_word(c_val));
            write_reg(REG_UNICODE, mode_word(u_val));
            write_reg(REG_UNUSED, {$urandom, $urandom});

            // the tail runs at full rate on both sides
            no_idle = (phase == RANDOM_PHASES - 1);

            // short texts ending in string_end, now and then a stray end mark
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 3))
                        0:       b = 8'($urandom_range(CTL_BEL, CTL_CR));
                        1:       b = 8'($urandom_range(CH_SPACE, CH_TILDE));
                        2:       b = 8'($urandom_range(8'h7f, 8'hff));
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    last = (k == len - 1) || ($urandom_range(0, 15) == 0);
                    send_text(b, last);
                    sent++;
                end
            end
        end

        // drain, then keep clocking for anything stray
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** byte_escape_encoder: PASSED **");
        end else begin
            $display("** byte_escape_encoder: FAILED **");
        end
        $finish;
    end

endmodule
